>>> rtl/cnv_pkg.sv
// ----------------------------------------------------------------------------
// Convolution and pooling package
// Shared widths and types for the 3x3 convolution, ReLU and max-pool block.
// ----------------------------------------------------------------------------
`default_nettype none
package cnv_pkg;
   localparam int PixelWidth = 8;
   localparam int ValueWidth = 18;
   localparam int SizeWidth  = 9;
   localparam int CsrWidth   = 24;
   localparam int CsrIdxWidth = 2;
   localparam int MinSize    = 5;

   typedef enum logic [CsrIdxWidth-1:0] {
      REG_IMAGE_SIZE = 2'd0,
      REG_KERNEL_TOP = 2'd1,
      REG_KERNEL_MID = 2'd2,
      REG_KERNEL_BOT = 2'd3
   } csr_index_type;

   typedef logic signed [PixelWidth-1:0] pixel_type;
   typedef logic [ValueWidth-1:0]        value_type;

   typedef struct packed {
      pixel_type pixel;
      logic      frame_start;
   } req_word_type;

   typedef struct packed {
      value_type pooled_value;
      logic      frame_last;
   } rsp_word_type;
endpackage
`default_nettype wire

>>> rtl/cnv_stream_if.sv
// ----------------------------------------------------------------------------
// Stream interface
// Valid/ready channel carrying one payload word.
// ----------------------------------------------------------------------------
`default_nettype none
interface cnv_stream_if #(parameter type word_type = logic) ();
   logic     valid;
   logic     ready;
   word_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/cnv_mac_cell.sv
// ----------------------------------------------------------------------------
// Convolution cell
// One window column: holds three pixels, hands them on to the older neighbor
// cell and adds its three products to the partial sum along the row.
// ----------------------------------------------------------------------------
`default_nettype none
module cnv_mac_cell (
   input  wire logic                   clock,
   input  wire logic                   enable,
   input  wire cnv_pkg::pixel_type     pix_top,
   input  wire cnv_pkg::pixel_type     pix_mid,
   input  wire cnv_pkg::pixel_type     pix_bot,
   input  wire cnv_pkg::pixel_type     k_top,
   input  wire cnv_pkg::pixel_type     k_mid,
   input  wire cnv_pkg::pixel_type     k_bot,
   input  wire logic signed [19:0]     sum_in,
   output cnv_pkg::pixel_type          top_ff,
   output cnv_pkg::pixel_type          mid_ff,
   output cnv_pkg::pixel_type          bot_ff,
   output logic signed [19:0]          sum_out
);
   import cnv_pkg::*;
   logic signed [19:0] local_w;

   assign local_w = 20'(top_ff * k_top) + 20'(mid_ff * k_mid) + 20'(bot_ff * k_bot);
   assign sum_out = sum_in + local_w;

   always_ff @(posedge clock) begin
      if (enable) begin
         top_ff <= pix_top;
         mid_ff <= pix_mid;
         bot_ff <= pix_bot;
      end
   end
endmodule
`default_nettype wire

>>> rtl/cnv_max_cell.sv
// ----------------------------------------------------------------------------
// Pooling cell
// One pooling column: maximum of three values and of the neighbor's result.
// ----------------------------------------------------------------------------
`default_nettype none
module cnv_max_cell (
   input  wire logic                clock,
   input  wire logic                enable,
   input  wire cnv_pkg::value_type  v_top,
   input  wire cnv_pkg::value_type  v_mid,
   input  wire cnv_pkg::value_type  v_bot,
   input  wire cnv_pkg::value_type  max_in,
   output cnv_pkg::value_type       max_ff
);
   import cnv_pkg::*;
   value_type a_w;
   value_type b_w;
   value_type max_in_w;

   always_comb begin
      a_w = (v_top > v_mid) ? v_top : v_mid;
      b_w = (v_bot > max_in) ? v_bot : max_in;
      max_in_w = (a_w > b_w) ? a_w : b_w;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         max_ff <= max_in_w;
      end
   end
endmodule
`default_nettype wire

>>> rtl/conv3x3_relu_maxpool3x3.sv
// ----------------------------------------------------------------------------
// 3x3 convolution, ReLU and 3x3 max pool
// Streams an N x N image of signed pixels and emits the pooled map.
// ----------------------------------------------------------------------------
// Usage: pixels enter on the req channel in raster order, frame_start on the
// first pixel of each image. One word is accepted per clock. Pixel and
// convolution rows are held in two line memories of three rows each; a row of
// three window cells forms the convolution sum and a row of three max cells
// forms the pooled value.
// A pooled word appears on rsp after the pixel completing its window passes
// the pixel line read, the window shift and multiply, and the convolution line
// read, after which the max cells load the output register. The pipeline
// advances only when its output register is empty or being taken, so a stalled
// rsp receiver holds req ready low while the output word waits. Throughput is
// one pixel per clock.
// Reset clears the position counters, the registers (size 5, kernel zero) and
// the pipeline valid bits; line memories are not cleared, as they are only
// read after being written in the same frame. CSR writes are taken at any
// edge with csr_write high and should occur only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none
module conv3x3_relu_maxpool3x3 #(
   parameter int MAX_IMAGE_SIZE = 256
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   cnv_stream_if.sink                              req,
   cnv_stream_if.source                            rsp,
   input  wire logic                               csr_write,
   input  wire logic [cnv_pkg::CsrIdxWidth-1:0]    csr_index,
   input  wire logic [cnv_pkg::CsrWidth-1:0]       csr_data
);
   import cnv_pkg::*;
   localparam int CW = $clog2(MAX_IMAGE_SIZE);
   localparam int PW = $clog2(MAX_IMAGE_SIZE + 1);

   logic [SizeWidth-1:0] size_ff;
   logic [CsrWidth-1:0]  krow_ff [3];
   logic [PW-1:0]        frame_ff;
   logic [PW-1:0]        row_ff, col_ff;
   logic [1:0]           rsel_ff;
   logic                 adv;
   logic [PW-1:0]        eff_w;

   always_comb begin
      if (size_ff < SizeWidth'(MinSize)) eff_w = PW'(MinSize);
      else if (32'(size_ff) > MAX_IMAGE_SIZE) eff_w = PW'(MAX_IMAGE_SIZE);
      else eff_w = PW'(size_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SizeWidth'(MinSize);
         krow_ff[0] <= '0; krow_ff[1] <= '0; krow_ff[2] <= '0;
      end else if (csr_write) begin
         case (csr_index_type'(csr_index))
            REG_IMAGE_SIZE: size_ff <= csr_data[SizeWidth-1:0];
            REG_KERNEL_TOP: krow_ff[0] <= csr_data;
            REG_KERNEL_MID: krow_ff[1] <= csr_data;
            REG_KERNEL_BOT: krow_ff[2] <= csr_data;
            default: ;
         endcase
      end
   end

   // Stage 0: position and pixel line memory.
   logic            acc;
   logic [PW-1:0]   r_w, c_w, n_w;
   logic [1:0]      rs_w;
   assign acc = req.valid && req.ready;
   always_comb begin
      if (req.data.frame_start) begin
         r_w = '0; c_w = '0; n_w = eff_w; rs_w = 2'd0;
      end else begin
         r_w = row_ff; c_w = col_ff; n_w = frame_ff; rs_w = rsel_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0; col_ff <= '0; frame_ff <= PW'(MinSize); rsel_ff <= 2'd0;
      end else if (acc) begin
         frame_ff <= n_w;
         if (c_w + 1'b1 >= n_w) begin
            col_ff <= '0;
            if (r_w + 1'b1 >= n_w) begin
               row_ff <= '0; rsel_ff <= 2'd0; frame_ff <= eff_w;
            end else begin
               row_ff <= r_w + 1'b1;
               rsel_ff <= (rs_w == 2'd2) ? 2'd0 : rs_w + 2'd1;
            end
         end else begin
            col_ff <= c_w + 1'b1;
            row_ff <= r_w; rsel_ff <= rs_w;
         end
      end
   end

   pixel_type pmem [3][MAX_IMAGE_SIZE];
   pixel_type p1_ff, p2_ff, p0_ff;
   logic      v1_ff, go1_ff, last1_ff;
   logic [1:0] rs1_ff;
   logic [CW-1:0] cc1_ff;
   logic [PW-1:0] cr1_ff;
   logic [1:0] ra_w, rb_w;
   assign ra_w = (rs_w == 2'd2) ? 2'd0 : rs_w + 2'd1;
   assign rb_w = (rs_w == 2'd0) ? 2'd2 : rs_w - 2'd1;

   always_ff @(posedge clock) begin
      if (acc) begin
         pmem[rs_w][c_w[CW-1:0]] <= req.data.pixel;
         p1_ff <= pmem[ra_w][c_w[CW-1:0]];
         p2_ff <= pmem[rb_w][c_w[CW-1:0]];
         p0_ff <= req.data.pixel;
         go1_ff <= (r_w >= PW'(2)) && (c_w >= PW'(2));
         last1_ff <= (r_w == n_w - 1'b1) && (c_w == n_w - 1'b1);
         cr1_ff <= r_w - PW'(2);
         cc1_ff <= CW'(c_w - PW'(2));
         rs1_ff <= (rs_w == 2'd0) ? 2'd1 : ((rs_w == 2'd1) ? 2'd2 : 2'd0);
      end
   end
   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (adv) v1_ff <= acc;
   end

   // Stage 1: window cells, oldest column in cell 0. Each step shifts the
   // newest pixel column in, and the cells add their products along the row.
   logic               step1;
   pixel_type          win_top [3], win_mid [3], win_bot [3];
   logic signed [19:0] part_w [4];
   assign step1 = adv && v1_ff;
   assign part_w[0] = '0;

   genvar g;
   generate
      for (g = 0; g < 3; g++) begin : g_mac
         pixel_type top_w, mid_w, bot_w;
         if (g == 2) begin : g_new
            assign top_w = p1_ff; assign mid_w = p2_ff; assign bot_w = p0_ff;
         end else begin : g_old
            assign top_w = win_top[g+1];
            assign mid_w = win_mid[g+1];
            assign bot_w = win_bot[g+1];
         end
         cnv_mac_cell u_cell (
            .clock  (clock),
            .enable (step1),
            .pix_top(top_w), .pix_mid(mid_w), .pix_bot(bot_w),
            .k_top  (pixel_type'(krow_ff[0][8*g +: 8])),
            .k_mid  (pixel_type'(krow_ff[1][8*g +: 8])),
            .k_bot  (pixel_type'(krow_ff[2][8*g +: 8])),
            .sum_in (part_w[g]),
            .top_ff (win_top[g]), .mid_ff(win_mid[g]), .bot_ff(win_bot[g]),
            .sum_out(part_w[g+1])
         );
      end
   endgenerate

   logic          v_ff, go_ff, last_ff;
   logic [PW-1:0] cr_ff;
   logic [CW-1:0] cc_ff;
   logic [1:0]    crs_ff;
   always_ff @(posedge clock) begin
      if (reset) v_ff <= 1'b0;
      else if (adv) v_ff <= v1_ff;
   end
   always_ff @(posedge clock) begin
      if (step1) begin
         go_ff <= go1_ff; last_ff <= last1_ff;
         cr_ff <= cr1_ff; cc_ff <= cc1_ff; crs_ff <= rs1_ff;
      end
   end
   logic signed [19:0] sum_w;
   assign sum_w = part_w[3];

   // Convolution line memory, read and written on the same step.
   value_type cmem [3][MAX_IMAGE_SIZE];
   value_type relu_w;
   logic cvalid_ff, clast_ff;
   assign relu_w = sum_w[19] ? '0 : value_type'(sum_w);

   // Conv row ring index tracks cr mod 3 per frame.
   logic [1:0] cwr_w, cra_w, crb_w;
   assign cwr_w = crs_ff;
   assign cra_w = (cwr_w == 2'd2) ? 2'd0 : cwr_w + 2'd1;
   assign crb_w = (cwr_w == 2'd0) ? 2'd2 : cwr_w - 2'd1;

   logic cgo_w;
   assign cgo_w = adv && v_ff && go_ff;
   value_type c1_ff, c2_ff, c0_ff;
   logic pv_ff;
   always_ff @(posedge clock) begin
      if (cgo_w) begin
         cmem[cwr_w][cc_ff] <= relu_w;
         c1_ff <= cmem[cra_w][cc_ff];
         c2_ff <= cmem[crb_w][cc_ff];
         c0_ff <= relu_w;
         cvalid_ff <= (cr_ff >= PW'(2)) && (cc_ff >= CW'(2));
         clast_ff <= last_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (reset) pv_ff <= 1'b0;
      else if (adv) pv_ff <= cgo_w;
   end

   // Max cells: cell g holds the maximum over the last g + 1 columns, so the
   // last cell holds the pooled value of the newest column.
   value_type m_ff [3];
   logic pstep;
   assign pstep = adv && pv_ff;
   generate
      for (g = 0; g < 3; g++) begin : g_max
         value_type prev_w;
         if (g == 0) begin : g_first
            assign prev_w = '0;
         end else begin : g_next
            assign prev_w = m_ff[g-1];
         end
         cnv_max_cell u_cell (
            .clock  (clock),
            .enable (pstep),
            .v_top  (c1_ff), .v_mid(c2_ff), .v_bot(c0_ff),
            .max_in (prev_w),
            .max_ff (m_ff[g])
         );
      end
   endgenerate

   logic out_v_ff, out_last_ff;
   assign adv = !out_v_ff || rsp.ready;
   assign req.ready = adv;
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (adv) begin
         out_v_ff <= pstep && cvalid_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (pstep) begin
         out_last_ff <= clast_ff;
      end
   end
   assign rsp.valid = out_v_ff;
   assign rsp.data  = {m_ff[2], out_last_ff};
endmodule
`default_nettype wire

>>> rtl/cnv_checker.sv
// ----------------------------------------------------------------------------
// Port checker
// Watches the top level's channels for handshake and reset behavior.
// ----------------------------------------------------------------------------
`default_nettype none
module cnv_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic req_ready
);
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("word dropped");
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("word after reset");
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready) else $error("stalled while empty");
endmodule

bind conv3x3_relu_maxpool3x3 cnv_checker u_checker (
   .clock(clock), .reset(reset), .rsp_valid(rsp.valid),
   .rsp_ready(rsp.ready), .req_ready(req.ready)
);
`default_nettype wire

>>> bench/conv3x3_relu_maxpool3x3_tb.sv
// ----------------------------------------------------------------------------
// Convolution and pooling testbench
// Streams square images of random signed pixels through the block under
// varying sizes and kernels, predicts each pooled word and checks it in order.
// ----------------------------------------------------------------------------
`default_nettype none
module conv3x3_relu_maxpool3x3_tb;
   import cnv_pkg::*;

   localparam int MaxSize    = 256;
   localparam int CycleLimit = 2000000;

   logic                   clock;
   logic                   reset;
   logic                   csr_write;
   logic [CsrIdxWidth-1:0] csr_index;
   logic [CsrWidth-1:0]    csr_data;

   cnv_stream_if #(.word_type(req_word_type)) req_ch ();
   cnv_stream_if #(.word_type(rsp_word_type)) rsp_ch ();

   conv3x3_relu_maxpool3x3 #(.MAX_IMAGE_SIZE(MaxSize)) dut (
      .clock(clock),
      .reset(reset),
      .req(req_ch),
      .rsp(rsp_ch),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   req_word_type pending_pixels[$];
   rsp_word_type expected_pooled[$];
   int           mismatches;
   int           cycles;
   int           pushed;
   bit           quiet;
   int           send_gap;
   int           take_gap;

   // Shadow copy of the registers and the pipeline state.
   logic [SizeWidth-1:0] size_reg;
   logic [CsrWidth-1:0]  kernel_reg[3];
   int pixel_rows[3][MaxSize];
   int conv_rows[3][MaxSize];
   int pixel_win[9];
   int conv_win[9];
   int row_pos;
   int col_pos;
   int frame_side;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int clamp_size();
      int n;
      n = size_reg;
      if (n < MinSize) n = MinSize;
      if (n > MaxSize) n = MaxSize;
      return n;
   endfunction

   function automatic void slide(ref int w[9], input int a, input int b, input int c);
      for (int i = 0; i < 3; i++) begin
         w[i*3] = w[i*3+1];
         w[i*3+1] = w[i*3+2];
      end
      w[2] = a;
      w[5] = b;
      w[8] = c;
   endfunction

   task automatic predict_pooled(input req_word_type word);
      int px;
      int sum;
      int peak;
      int cr;
      int cc;
      logic signed [7:0] k;
      rsp_word_type out;
      px = word.pixel;
      if (word.frame_start) begin
         row_pos = 0;
         col_pos = 0;
         frame_side = clamp_size();
      end
      pixel_rows[row_pos % 3][col_pos] = px;
      slide(pixel_win, pixel_rows[(row_pos + 1) % 3][col_pos],
            pixel_rows[(row_pos + 2) % 3][col_pos], px);
      if (row_pos >= 2 && col_pos >= 2) begin
         cr = row_pos - 2;
         cc = col_pos - 2;
         sum = 0;
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               k = kernel_reg[i][8*j +: 8];
               sum += pixel_win[i*3+j] * int'(k);
            end
         end
         if (sum < 0) sum = 0;
         conv_rows[cr % 3][cc] = sum;
         slide(conv_win, conv_rows[(cr + 1) % 3][cc], conv_rows[(cr + 2) % 3][cc], sum);
         if (cr >= 2 && cc >= 2) begin
            peak = conv_win[0];
            for (int i = 1; i < 9; i++) if (conv_win[i] > peak) peak = conv_win[i];
            out.pooled_value = peak[ValueWidth-1:0];
            out.frame_last = (row_pos == frame_side - 1) && (col_pos == frame_side - 1);
            expected_pooled = {expected_pooled, out};
         end
      end
      col_pos++;
      if (col_pos >= frame_side) begin
         col_pos = 0;
         row_pos++;
         if (row_pos >= frame_side) begin
            row_pos = 0;
            frame_side = clamp_size();
         end
      end
   endtask

   task automatic report(input string what, input int got, input int want);
      $display("mismatch on %s: got %0d, expected %0d", what, got, want);
      mismatches++;
   endtask

   // Driver for the pixel channel.
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.data <= '0;
         send_gap <= 0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_ch.valid <= 1'b0;
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            send_gap <= $urandom_range(0, 7);
            req_ch.valid <= 1'b0;
         end else if (pending_pixels.size() > 0) begin
            req_ch.data <= pending_pixels.pop_front();
            req_ch.valid <= 1'b1;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Receiver stalls on the result channel.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         take_gap <= 0;
      end else if (take_gap > 0) begin
         take_gap <= take_gap - 1;
         rsp_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
         take_gap <= $urandom_range(0, 7);
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // Monitor: predict on each accepted pixel, check each accepted pooled word.
   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) predict_pooled(req_ch.data);
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_pooled.size() == 0) begin
               report("unexpected word", rsp_ch.data.pooled_value, -1);
            end else begin
               want = expected_pooled.pop_front();
               if (rsp_ch.data.pooled_value !== want.pooled_value)
                  report("pooled_value", rsp_ch.data.pooled_value, want.pooled_value);
               if (rsp_ch.data.frame_last !== want.frame_last)
                  report("frame_last", rsp_ch.data.frame_last, want.frame_last);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic write_reg(input csr_index_type idx, input logic [CsrWidth-1:0] value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      if (idx == REG_IMAGE_SIZE) size_reg = value[SizeWidth-1:0];
      else kernel_reg[int'(idx) - 1] = value;
   endtask

   task automatic configure(input logic [SizeWidth-1:0] side, input logic [CsrWidth-1:0] top,
                            input logic [CsrWidth-1:0] mid, input logic [CsrWidth-1:0] bot);
      write_reg(REG_IMAGE_SIZE, CsrWidth'(side));
      write_reg(REG_KERNEL_TOP, top);
      write_reg(REG_KERNEL_MID, mid);
      write_reg(REG_KERNEL_BOT, bot);
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic wait_idle();
      while (pending_pixels.size() > 0 || req_ch.valid || expected_pooled.size() > 0)
         @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   function automatic logic signed [7:0] random_pixel();
      case ($urandom_range(0, 7))
         0: return 8'sh80;
         1: return 8'sh7f;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // A frame of count pixels; with_start chooses the first word's flag, and a
   // stray start flag now and then restarts the position early.
   task automatic add_frame(input int count, input bit with_start);
      req_word_type w;
      for (int i = 0; i < count; i++) begin
         w.pixel = random_pixel();
         w.frame_start = (i == 0) ? with_start : ($urandom_range(0, 199) == 0);
         pending_pixels = {pending_pixels, w};
         pushed++;
      end
   endtask

   function automatic logic [CsrWidth-1:0] random_kernel();
      case ($urandom_range(0, 5))
         0: return 24'h808080;
         1: return 24'h7f7f7f;
         default: return 24'($urandom());
      endcase
   endfunction

   initial begin
      req_word_type w;
      int side;
      int frames;
      csr_write = 1'b0;
      csr_index = '0;
      csr_data = '0;
      cycles = 0;
      mismatches = 0;
      pushed = 0;
      quiet = 1'b0;
      size_reg = 9'd5;
      kernel_reg[0] = '0;
      kernel_reg[1] = '0;
      kernel_reg[2] = '0;
      row_pos = 0;
      col_pos = 0;
      frame_side = 5;
      foreach (pixel_win[i]) pixel_win[i] = 0;
      foreach (conv_win[i]) conv_win[i] = 0;
      reset = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: size below range acts as five, extreme pixels and kernels.
      configure(9'd0, 24'h7f807f, 24'h80007f, 24'h017f80);
      for (int i = 0; i < 25; i++) begin
         w.frame_start = (i == 0);
         case (i % 3)
            0: w.pixel = 8'sh80;
            1: w.pixel = 8'sh7f;
            default: w.pixel = 8'sh00;
         endcase
         pending_pixels = {pending_pixels, w};
      end
      wait_idle();

      // Size above range acts as the maximum: the first rows of a large frame
      // wrap at the maximum width and reach the first pooled words.
      configure(9'd511, random_kernel(), random_kernel(), random_kernel());
      for (int i = 0; i < 4 * MaxSize + 8; i++) begin
         w.pixel = random_pixel();
         w.frame_start = (i == 0);
         pending_pixels = {pending_pixels, w};
         pushed++;
      end
      wait_idle();

      while (pushed < 1350) begin
         if (pushed > 1250) quiet = 1'b1;
         case ($urandom_range(0, 7))
            0: side = $urandom_range(0, 4);
            1: side = $urandom_range(11, 20);
            default: side = $urandom_range(5, 10);
         endcase
         configure(side[SizeWidth-1:0], random_kernel(), random_kernel(), random_kernel());
         frames = $urandom_range(1, 4);
         for (int f = 0; f < frames; f++) begin
            side = clamp_size();
            case ($urandom_range(0, 5))
               // An early restart leaves a partial frame.
               0: add_frame($urandom_range(1, side * side - 1), 1'b1);
               // No start flag: the position wraps on its own, and after a
               // size write mid-frame the old frame is finished first.
               1: add_frame(side * side, 1'b0);
               default: add_frame(side * side, 1'b1);
            endcase
         end
         wait_idle();
      end

      quiet = 1'b1;
      wait_idle();
      if (mismatches == 0 && expected_pooled.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
`default_nettype wire
